// ===== rtl/aabb_pair_collision_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the AABB pair collision tracker
// Clocked concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef AABB_PAIR_COLLISION_TRACKER_UNIT_ASSERT_SVH
`define AABB_PAIR_COLLISION_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define AABB_PT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aabb_pt assertion failed");
`define AABB_PT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("aabb_pt assertion failed");
`else
`define AABB_PT_ASSERT(lbl, prop)
`define AABB_PT_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/aabb_pt_pkg.sv =====
// ----------------------------------------------------------------------------
// AABB pair tracker package
// Shared constants, payload structs and cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package aabb_pt_pkg;

  localparam int MAX_COLLIDERS_DEF = 8;
  localparam int COORD_BITS_DEF    = 24;

  localparam int ID_W    = 3;
  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int LAYER_W = 5;
  localparam int MASK_W  = 32;
  localparam int KIND_W  = 2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_STARTED   = 2'd0;
  localparam logic [KIND_W-1:0] EV_CONTINUES = 2'd1;
  localparam logic [KIND_W-1:0] EV_ENDED     = 2'd2;
  localparam logic [KIND_W-1:0] EV_NONE      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]          collider_id;
    logic signed [POS_W-1:0]  left_x;
    logic signed [POS_W-1:0]  top_y;
    logic [SIZE_W-1:0]        box_width;
    logic [SIZE_W-1:0]        box_height;
    logic [LAYER_W-1:0]       layer_index;
    logic [MASK_W-1:0]        layer_mask;
    logic                     last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   first_id;
    logic [ID_W-1:0]   second_id;
    logic [KIND_W-1:0] event_kind;
    logic              last_event;
  } out_item_t;

  // per-cell control
  typedef struct packed {
    logic load;       // store the incoming collider
    logic load_trav;  // copy own record into the traveling register
    logic shift;      // take the neighbor's traveling record
    logic pres_clr;   // end of frame: drop presence
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/aabb_pair_collision_tracker_unit.sv =====
// Sequence: collider items load while the unit is idle; the frame's last
// item starts the traveling-copy load and the ring shifts, then a pair scan
// in three passes (started, continuing, ended) over MAX_COLLIDERS*(MAX_COLLIDERS-1)/2
// pairs, stretched by output stalls, then the last event of the frame.
// Reset: asynchronous active low; clears presence flags and previous-frame hits.
// ----------------------------------------------------------------------------
// AABB pair collision tracker
// Ring of collider cells for pair testing, then a scan that reports
// started, continuing and ended pairs against the previous frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_pair_collision_tracker_unit_assert.svh"
module aabb_pair_collision_tracker_unit #(
  parameter int MAX_COLLIDERS = aabb_pt_pkg::MAX_COLLIDERS_DEF,
  parameter int COORD_BITS    = aabb_pt_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire aabb_pt_pkg::in_item_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output aabb_pt_pkg::out_item_t      out_data_o
);

  localparam int N     = MAX_COLLIDERS;
  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(N);
  localparam int IW    = ((IDX_W > aabb_pt_pkg::ID_W) ? IDX_W : aabb_pt_pkg::ID_W) + 1;
  localparam int PW    = 2*CB + 2*(CB-1) + aabb_pt_pkg::LAYER_W + aabb_pt_pkg::MASK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N-1);
  localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(N-2);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOADT = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic in_acc, out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // incoming slot decode
  logic [IW-1:0] id_ext;
  logic          id_ok;
  assign id_ext = IW'(in_data_i.collider_id);
  assign id_ok  = id_ext < IW'(N);

  logic [PW-1:0] wr_rec;
  assign wr_rec = {CB'($unsigned(in_data_i.left_x)), CB'($unsigned(in_data_i.top_y)),
                   (CB-1)'(in_data_i.box_width), (CB-1)'(in_data_i.box_height),
                   in_data_i.layer_index, in_data_i.layer_mask};

  // ring of cells
  logic [PW:0] trav [N];
  logic [N-1:0] hit;
  logic [IDX_W-1:0] s_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    aabb_pt_pkg::cell_ctl_t ctl;
    assign ctl.load      = in_acc && id_ok && (id_ext == IW'(k));
    assign ctl.load_trav = (state_q == ST_LOADT);
    assign ctl.shift     = (state_q == ST_EVAL);
    assign ctl.pres_clr  = (state_q == ST_FIN) && out_free;

    aabb_pt_cell #(.CB(CB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .wr_i   (wr_rec),
      .trav_i (trav[(k + N - 1) % N]),
      .trav_o (trav[k]),
      .hit_o  (hit[k])
    );
  end

  // hit rows: bit d of row j is pair (j-d, j)
  logic [N-1:0] now_q   [N];
  logic [N-1:0] prior_q [N];

  for (genvar k = 0; k < N; k++) begin : g_row
    localparam logic [IDX_W-1:0] KI = IDX_W'(k);
    always_ff @(posedge clk_i) begin
      if (state_q == ST_EVAL && s_q != '0 && s_q <= KI) begin
        now_q[k][s_q] <= hit[k];
      end
    end
  end

  // previous-frame hits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < N; r++) begin
        prior_q[r] <= '0;
      end
    end else if (state_q == ST_FIN && out_free) begin
      for (int r = 0; r < N; r++) begin
        prior_q[r] <= now_q[r];
      end
    end
  end

  // scan counters and pending event
  logic [IDX_W-1:0] i_q, j_q, i_d, j_d, s_d, pair_gap;
  logic [aabb_pt_pkg::KIND_W-1:0] g_q, g_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d;
  aabb_pt_pkg::out_item_t pend_q, pend_d, out_q, out_d;
  logic cur_now, cur_prior, emit, scan_step, scan_done;

  assign pair_gap  = j_q - i_q;
  assign cur_now   = now_q[j_q][pair_gap];
  assign cur_prior = prior_q[j_q][pair_gap];
  assign scan_done = (j_q == LAST_IDX) && (i_q == PEN_IDX)
                  && (g_q == aabb_pt_pkg::EV_ENDED);

  always_comb begin
    unique case (g_q)
      aabb_pt_pkg::EV_STARTED:   emit = cur_now && !cur_prior;
      aabb_pt_pkg::EV_CONTINUES: emit = cur_now && cur_prior;
      aabb_pt_pkg::EV_ENDED:     emit = !cur_now && cur_prior;
      default:                   emit = 1'b0;
    endcase
  end

  assign scan_step = !(emit && pend_v_q && !out_free);

  // control sequencer
  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    i_d      = i_q;
    j_d      = j_q;
    g_d      = g_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.last_of_frame) begin
          state_d = ST_LOADT;
        end
      end
      ST_LOADT: begin
        s_d     = '0;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        s_d = s_q + 1'b1;
        if (s_q == LAST_IDX) begin
          i_d     = '0;
          j_d     = IDX_W'(1);
          g_d     = aabb_pt_pkg::EV_STARTED;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          if (emit) begin
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = pend_q;
            end
            pend_v_d          = 1'b1;
            pend_d.first_id   = aabb_pt_pkg::ID_W'(i_q);
            pend_d.second_id  = aabb_pt_pkg::ID_W'(j_q);
            pend_d.event_kind = g_q;
            pend_d.last_event = 1'b0;
          end
          if (scan_done) begin
            state_d = ST_FIN;
          end else if (j_q != LAST_IDX) begin
            j_d = j_q + 1'b1;
          end else if (i_q != PEN_IDX) begin
            i_d = i_q + 1'b1;
            j_d = i_q + IDX_W'(2);
          end else begin
            i_d = '0;
            j_d = IDX_W'(1);
            g_d = g_q + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d = 1'b1;
          if (pend_v_q) begin
            out_d            = pend_q;
            out_d.last_event = 1'b1;
          end else begin
            out_d.first_id   = '0;
            out_d.second_id  = '0;
            out_d.event_kind = aabb_pt_pkg::EV_NONE;
            out_d.last_event = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      s_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      g_q      <= aabb_pt_pkg::EV_STARTED;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      s_q      <= s_d;
      i_q      <= i_d;
      j_q      <= j_d;
      g_q      <= g_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  `AABB_PT_ASSERT(a_state_onehot, $onehot(state_q))
  `AABB_PT_ASSERT(a_idle_no_pending, state_q == ST_IDLE |-> !pend_v_q)
  `AABB_PT_ASSERT(a_scan_order, state_q == ST_SCAN |-> i_q < j_q)
  `AABB_PT_ASSERT(a_marker_ids,
    out_v_q && out_q.event_kind == aabb_pt_pkg::EV_NONE |->
      out_q.first_id == '0 && out_q.second_id == '0 && out_q.last_event)

endmodule
`default_nettype wire

// ===== rtl/aabb_pt_cell.sv =====
// ----------------------------------------------------------------------------
// AABB pair tracker cell
// Holds one collider slot plus a traveling copy passed along the ring, and
// tests the held collider against the traveling one.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_pt_cell #(
  parameter int CB = aabb_pt_pkg::COORD_BITS_DEF,
  localparam int PW = 2*CB + 2*(CB-1) + aabb_pt_pkg::LAYER_W + aabb_pt_pkg::MASK_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire aabb_pt_pkg::cell_ctl_t ctl_i,
  input  wire logic [PW-1:0]          wr_i,
  input  wire logic [PW:0]            trav_i,
  output logic [PW:0]                 trav_o,
  output logic                        hit_o
);

  logic [PW-1:0] rec_q;
  logic          pres_q;
  logic [PW:0]   trav_q;

  // stored slot payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rec_q <= wr_i;
    end
  end

  // presence flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= 1'b0;
    end else if (ctl_i.load) begin
      pres_q <= 1'b1;
    end else if (ctl_i.pres_clr) begin
      pres_q <= 1'b0;
    end
  end

  // traveling record
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_trav) begin
      trav_q <= {pres_q, rec_q};
    end else if (ctl_i.shift) begin
      trav_q <= trav_i;
    end
  end

  assign trav_o = trav_q;

  // unpack both records
  logic [CB-1:0] al, at, bl, bt;
  logic [CB-2:0] aw, ah, bw, bh;
  logic [aabb_pt_pkg::LAYER_W-1:0] alay, blay;
  logic [aabb_pt_pkg::MASK_W-1:0]  amsk, bmsk;
  logic bpres;

  assign {al, at, aw, ah, alay, amsk}        = rec_q;
  assign {bpres, bl, bt, bw, bh, blay, bmsk} = trav_q;

  // closed-interval overlap at one extra bit, no overflow
  logic signed [CB:0] axl, axr, ayt, ayb, bxl, bxr, byt, byb;

  always_comb begin
    axl = {al[CB-1], al};
    ayt = {at[CB-1], at};
    bxl = {bl[CB-1], bl};
    byt = {bt[CB-1], bt};
    axr = axl + $signed({2'b00, aw});
    ayb = ayt + $signed({2'b00, ah});
    bxr = bxl + $signed({2'b00, bw});
    byb = byt + $signed({2'b00, bh});
  end

  assign hit_o = pres_q && bpres
              && !(axl > bxr) && !(axr < bxl)
              && !(ayt > byb) && !(ayb < byt)
              && amsk[blay] && bmsk[alay];

endmodule
`default_nettype wire
